[design/tile_grid_test_pattern_core_macros.svh]
// Assertion macros for the tile grid test pattern checker.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef TILE_GRID_TEST_PATTERN_CORE_MACROS_SVH
`define TILE_GRID_TEST_PATTERN_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGTP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tgtp: same-cycle check failed");

// The consequent must hold after the antecedent, delayed by the argument n.
`define TGTP_ASSERT_DELAY(lbl, clk, rst, ante, n, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
      else $error("tgtp: delayed check failed");

`endif

[design/tgtp_pkg.sv]
// Package for the tile grid test pattern core: widths, register indexes,
// reset values, palette table and modulo-seven helpers. Depends on nothing.
package tgtp_pkg;

   localparam int unsigned MAX_DIMENSION_DEFAULT = 4096;
   localparam int unsigned COORD_W   = 12;
   localparam int unsigned TILE_W    = 8;
   localparam int unsigned FRAME_W   = 13;
   localparam int unsigned NUM_W     = COORD_W + TILE_W;
   localparam int unsigned ADDR_W    = 26;
   localparam int unsigned WORD_W    = 32;
   localparam int unsigned SHIFTS_W  = 20;
   localparam int unsigned STRIDE_W  = 15;
   localparam int unsigned CSR_W     = 20;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned INDEX_W   = 3;
   localparam int unsigned COLOR_W   = 24;
   localparam int unsigned PALETTE_SIZE = 7;
   // Front stage, one cell per quotient bit, index stage, packing stage.
   localparam int unsigned LATENCY   = NUM_W + 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH    = 3'd0,
      CSR_FRAME_HEIGHT   = 3'd1,
      CSR_TILE_COLUMNS   = 3'd2,
      CSR_TILE_ROWS      = 3'd3,
      CSR_WIDE_FORMAT    = 3'd4,
      CSR_CHANNEL_SHIFTS = 3'd5,
      CSR_ALPHA_ENABLE   = 3'd6,
      CSR_LINE_STRIDE    = 3'd7
   } csr_index_type;

   localparam logic [FRAME_W-1:0]  FRAME_WIDTH_RESET    = 13'd1920;
   localparam logic [FRAME_W-1:0]  FRAME_HEIGHT_RESET   = 13'd1080;
   localparam logic [TILE_W-1:0]   TILE_COLUMNS_RESET   = 8'd6;
   localparam logic [TILE_W-1:0]   TILE_ROWS_RESET      = 8'd4;
   localparam logic                WIDE_FORMAT_RESET    = 1'b1;
   localparam logic [SHIFTS_W-1:0] CHANNEL_SHIFTS_RESET = 20'd407584;
   localparam logic                ALPHA_ENABLE_RESET   = 1'b1;
   localparam logic [STRIDE_W-1:0] LINE_STRIDE_RESET    = 15'd7680;

   localparam logic [COLOR_W-1:0] DIM_MASK = 24'h7f7f7f;

   // Red, green, blue, yellow, magenta, cyan, white; the last entry is unused.
   localparam logic [COLOR_W-1:0] PALETTE [8] = '{
      24'hff0000, 24'h00ff00, 24'h0000ff, 24'hffff00,
      24'hff00ff, 24'h00ffff, 24'hffffff, 24'h000000
   };

   typedef struct packed {
      logic                wide_format;
      logic [SHIFTS_W-1:0] channel_shifts;
      logic                alpha_enable;
   } pack_cfg_type;

   // Eight is one more than seven, so octal digits can be summed.
   function automatic logic [INDEX_W-1:0] mod7_u8(input logic [7:0] v);
      logic [4:0] s;
      logic [3:0] t;
      s = 5'(v[7:6]) + 5'(v[5:3]) + 5'(v[2:0]);
      t = 4'(s[4:3]) + 4'(s[2:0]);
      if (t >= 4'd7) begin
         t = t - 4'd7;
      end
      return t[INDEX_W-1:0];
   endfunction

   // Appends one quotient bit to a running value kept modulo seven.
   function automatic logic [INDEX_W-1:0] mod7_step(input logic [INDEX_W-1:0] m,
                                                    input logic b);
      logic [3:0] t;
      t = {m, b};
      if (t >= 4'd7) begin
         t = t - 4'd7;
      end
      return t[INDEX_W-1:0];
   endfunction

endpackage

[design/tgtp_front.sv]
// Entry stage of the tile grid test pattern core: forms both dividends and
// the byte address of an accepted item. Depends on tgtp_pkg.
module tgtp_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic [tgtp_pkg::COORD_W-1:0]         pixel_x,
   input  logic [tgtp_pkg::COORD_W-1:0]         pixel_y,
   input  logic [tgtp_pkg::TILE_W-1:0]          tile_columns,
   input  logic [tgtp_pkg::TILE_W-1:0]          tile_rows,
   input  logic [tgtp_pkg::STRIDE_W-1:0]        line_stride,
   input  logic                                 wide_format,
   output logic                                 valid_ff,
   output logic [tgtp_pkg::NUM_W-1:0]           col_num_ff,
   output logic [tgtp_pkg::NUM_W-1:0]           row_num_ff,
   output logic [tgtp_pkg::ADDR_W-1:0]          addr_ff
);

   localparam int unsigned LINE_W = tgtp_pkg::COORD_W + tgtp_pkg::STRIDE_W;

   logic [tgtp_pkg::NUM_W-1:0]   col_num_in;
   logic [tgtp_pkg::NUM_W-1:0]   row_num_in;
   logic [LINE_W-1:0]            line_offset;
   logic [tgtp_pkg::COORD_W+1:0] pixel_offset;
   logic [tgtp_pkg::ADDR_W-1:0]  addr_in;

   always_comb begin
      col_num_in   = tgtp_pkg::NUM_W'(pixel_x) * tgtp_pkg::NUM_W'(tile_columns);
      row_num_in   = tgtp_pkg::NUM_W'(pixel_y) * tgtp_pkg::NUM_W'(tile_rows);
      line_offset  = LINE_W'(pixel_y) * LINE_W'(line_stride);
      pixel_offset = wide_format ? {pixel_x, 2'b00} : {1'b0, pixel_x, 1'b0};
      addr_in      = tgtp_pkg::ADDR_W'(line_offset + LINE_W'(pixel_offset));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      col_num_ff <= col_num_in;
      row_num_ff <= row_num_in;
      addr_ff    <= addr_in;
   end

endmodule

[design/tgtp_cell.sv]
// One cell of the divider chain: a restoring division step for the tile
// column and the tile row of one item. Depends on tgtp_pkg.
module tgtp_cell #(
   parameter int unsigned DIV_W = 13
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [DIV_W-1:0]                    col_divisor,
   input  logic [DIV_W-1:0]                    row_divisor,
   input  logic                                valid_i,
   input  logic [DIV_W-1:0]                    col_rem_i,
   input  logic [tgtp_pkg::NUM_W-1:0]          col_num_i,
   input  logic [tgtp_pkg::INDEX_W-1:0]        col_mod_i,
   input  logic [DIV_W-1:0]                    row_rem_i,
   input  logic [tgtp_pkg::NUM_W-1:0]          row_num_i,
   input  logic [tgtp_pkg::NUM_W-1:0]          row_quot_i,
   input  logic [tgtp_pkg::INDEX_W-1:0]        row_mod_i,
   input  logic [tgtp_pkg::ADDR_W-1:0]         addr_i,
   output logic                                valid_ff,
   output logic [DIV_W-1:0]                    col_rem_ff,
   output logic [tgtp_pkg::NUM_W-1:0]          col_num_ff,
   output logic [tgtp_pkg::INDEX_W-1:0]        col_mod_ff,
   output logic [DIV_W-1:0]                    row_rem_ff,
   output logic [tgtp_pkg::NUM_W-1:0]          row_num_ff,
   output logic [tgtp_pkg::NUM_W-1:0]          row_quot_ff,
   output logic [tgtp_pkg::INDEX_W-1:0]        row_mod_ff,
   output logic [tgtp_pkg::ADDR_W-1:0]         addr_ff
);

   logic [DIV_W:0]                   col_trial;
   logic [DIV_W:0]                   col_diff;
   logic                             col_ge;
   logic [DIV_W-1:0]                 col_rem_in;
   logic [tgtp_pkg::INDEX_W-1:0]     col_mod_in;
   logic [DIV_W:0]                   row_trial;
   logic [DIV_W:0]                   row_diff;
   logic                             row_ge;
   logic [DIV_W-1:0]                 row_rem_in;
   logic [tgtp_pkg::INDEX_W-1:0]     row_mod_in;

   always_comb begin
      col_trial  = {col_rem_i, col_num_i[tgtp_pkg::NUM_W-1]};
      col_diff   = col_trial - {1'b0, col_divisor};
      col_ge     = col_trial >= {1'b0, col_divisor};
      col_rem_in = col_ge ? col_diff[DIV_W-1:0] : col_trial[DIV_W-1:0];
      col_mod_in = tgtp_pkg::mod7_step(col_mod_i, col_ge);

      row_trial  = {row_rem_i, row_num_i[tgtp_pkg::NUM_W-1]};
      row_diff   = row_trial - {1'b0, row_divisor};
      row_ge     = row_trial >= {1'b0, row_divisor};
      row_rem_in = row_ge ? row_diff[DIV_W-1:0] : row_trial[DIV_W-1:0];
      row_mod_in = tgtp_pkg::mod7_step(row_mod_i, row_ge);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      col_rem_ff  <= col_rem_in;
      col_num_ff  <= {col_num_i[tgtp_pkg::NUM_W-2:0], 1'b0};
      col_mod_ff  <= col_mod_in;
      row_rem_ff  <= row_rem_in;
      row_num_ff  <= {row_num_i[tgtp_pkg::NUM_W-2:0], 1'b0};
      row_quot_ff <= {row_quot_i[tgtp_pkg::NUM_W-2:0], row_ge};
      row_mod_ff  <= row_mod_in;
      addr_ff     <= addr_i;
   end

endmodule

[design/tgtp_color.sv]
// Last two stages of the tile grid test pattern core: palette index and
// dimming, then the packed pixel word. Depends on tgtp_pkg.
module tgtp_color (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 valid_i,
   input  logic [tgtp_pkg::INDEX_W-1:0]         col_mod_i,
   input  logic [tgtp_pkg::INDEX_W-1:0]         row_mod_i,
   input  logic [tgtp_pkg::NUM_W-1:0]           row_quot_i,
   input  logic [tgtp_pkg::ADDR_W-1:0]          addr_i,
   input  logic [tgtp_pkg::TILE_W-1:0]          tile_columns,
   input  logic [tgtp_pkg::TILE_W-1:0]          tile_rows,
   input  logic                                 width_zero,
   input  logic                                 height_zero,
   input  tgtp_pkg::pack_cfg_type               pack_cfg,
   output logic                                 rsp_valid_ff,
   output logic [tgtp_pkg::WORD_W-1:0]          rsp_pixel_word_ff,
   output logic [tgtp_pkg::ADDR_W-1:0]          rsp_byte_address_ff,
   output logic [tgtp_pkg::INDEX_W-1:0]         rsp_palette_index_ff,
   output logic                                 rsp_dimmed_ff
);

   logic [tgtp_pkg::INDEX_W-1:0] col_mod;
   logic [tgtp_pkg::INDEX_W-1:0] row_mod;
   logic [tgtp_pkg::NUM_W-1:0]   row_quot;
   logic [5:0]                   grid_prod;
   logic [7:0]                   grid_sum;
   logic [tgtp_pkg::INDEX_W-1:0] index_in;
   logic                         dim_in;

   logic                         valid_ff;
   logic [tgtp_pkg::INDEX_W-1:0] index_ff;
   logic                         dim_ff;
   logic [tgtp_pkg::ADDR_W-1:0]  addr_ff;

   logic [tgtp_pkg::COLOR_W-1:0] color;
   logic [4:0]                   red_shift;
   logic [4:0]                   green_shift;
   logic [4:0]                   blue_shift;
   logic [4:0]                   alpha_shift;
   logic [tgtp_pkg::WORD_W-1:0]  word_in;

   always_comb begin
      col_mod   = width_zero ? '0 : col_mod_i;
      row_mod   = height_zero ? '0 : row_mod_i;
      row_quot  = height_zero ? '0 : row_quot_i;
      grid_prod = 6'(row_mod) * 6'(tgtp_pkg::mod7_u8(tile_columns));
      grid_sum  = 8'(grid_prod) + 8'(col_mod);
      index_in  = tgtp_pkg::mod7_u8(grid_sum);
      dim_in    = row_quot >= tgtp_pkg::NUM_W'(tile_rows >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      index_ff <= index_in;
      dim_ff   <= dim_in;
      addr_ff  <= addr_i;
   end

   always_comb begin
      color = tgtp_pkg::PALETTE[index_ff];
      if (dim_ff) begin
         color = (color >> 1) & tgtp_pkg::DIM_MASK;
      end
      red_shift   = pack_cfg.channel_shifts[19:15];
      green_shift = pack_cfg.channel_shifts[14:10];
      blue_shift  = pack_cfg.channel_shifts[9:5];
      alpha_shift = pack_cfg.channel_shifts[4:0];
      if (pack_cfg.wide_format) begin
         word_in = (tgtp_pkg::WORD_W'(color[23:16]) << red_shift)
                 | (tgtp_pkg::WORD_W'(color[15:8]) << green_shift)
                 | (tgtp_pkg::WORD_W'(color[7:0]) << blue_shift);
         if (pack_cfg.alpha_enable) begin
            word_in = word_in | (tgtp_pkg::WORD_W'(8'hff) << alpha_shift);
         end
      end else begin
         word_in = {16'd0, color[23:19], color[15:10], color[7:3]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pixel_word_ff    <= word_in;
      rsp_byte_address_ff  <= addr_ff;
      rsp_palette_index_ff <= index_ff;
      rsp_dimmed_ff        <= dim_ff;
   end

endmodule

[design/tile_grid_test_pattern_core.sv]
// Top level of the tile grid test pattern core: register file, entry stage,
// divider chain of tgtp_cell and the color stages. Depends on tgtp_pkg.
//
// The core takes one pixel coordinate in every clock cycle and returns its
// pattern word, byte address, palette index and dim flag, one item per cycle
// with no gaps, so busy stays low. Its stages are one entry stage, a divider
// chain with one cell per quotient bit of the 20-bit product of coordinate
// and tile count, and two color stages. The receiver cannot stall; every
// result is shown for exactly one cycle under rsp_valid. The user must write
// registers only while no item is in flight; the core does not enforce it.
module tile_grid_test_pattern_core #(
   parameter int unsigned MAX_DIMENSION = tgtp_pkg::MAX_DIMENSION_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [tgtp_pkg::COORD_W-1:0]         req_pixel_x,
   input  logic [tgtp_pkg::COORD_W-1:0]         req_pixel_y,
   output logic                                 rsp_valid,
   output logic [tgtp_pkg::WORD_W-1:0]          rsp_pixel_word,
   output logic [tgtp_pkg::ADDR_W-1:0]          rsp_byte_address,
   output logic [tgtp_pkg::INDEX_W-1:0]         rsp_palette_index,
   output logic                                 rsp_dimmed,
   input  logic                                 csr_write_enable,
   input  logic [tgtp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tgtp_pkg::CSR_W-1:0]           csr_write_data
);

   localparam int unsigned DIV_W = $clog2(MAX_DIMENSION + 1);
   localparam int unsigned NUM_W = tgtp_pkg::NUM_W;
   localparam logic [DIV_W-1:0] MAX_DIV = DIV_W'(MAX_DIMENSION);

   logic [tgtp_pkg::FRAME_W-1:0]  frame_width_ff;
   logic [tgtp_pkg::FRAME_W-1:0]  frame_height_ff;
   logic [tgtp_pkg::TILE_W-1:0]   tile_columns_ff;
   logic [tgtp_pkg::TILE_W-1:0]   tile_rows_ff;
   logic                          wide_format_ff;
   logic [tgtp_pkg::SHIFTS_W-1:0] channel_shifts_ff;
   logic                          alpha_enable_ff;
   logic [tgtp_pkg::STRIDE_W-1:0] line_stride_ff;

   logic [31:0]                   width_wide;
   logic [31:0]                   height_wide;
   logic [DIV_W-1:0]              col_divisor;
   logic [DIV_W-1:0]              row_divisor;
   logic                          width_zero;
   logic                          height_zero;
   tgtp_pkg::pack_cfg_type        pack_cfg;

   logic                          chain_valid    [NUM_W+1];
   logic [DIV_W-1:0]              chain_col_rem  [NUM_W+1];
   logic [NUM_W-1:0]              chain_col_num  [NUM_W+1];
   logic [tgtp_pkg::INDEX_W-1:0]  chain_col_mod  [NUM_W+1];
   logic [DIV_W-1:0]              chain_row_rem  [NUM_W+1];
   logic [NUM_W-1:0]              chain_row_num  [NUM_W+1];
   logic [NUM_W-1:0]              chain_row_quot [NUM_W+1];
   logic [tgtp_pkg::INDEX_W-1:0]  chain_row_mod  [NUM_W+1];
   logic [tgtp_pkg::ADDR_W-1:0]   chain_addr     [NUM_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff    <= tgtp_pkg::FRAME_WIDTH_RESET;
         frame_height_ff   <= tgtp_pkg::FRAME_HEIGHT_RESET;
         tile_columns_ff   <= tgtp_pkg::TILE_COLUMNS_RESET;
         tile_rows_ff      <= tgtp_pkg::TILE_ROWS_RESET;
         wide_format_ff    <= tgtp_pkg::WIDE_FORMAT_RESET;
         channel_shifts_ff <= tgtp_pkg::CHANNEL_SHIFTS_RESET;
         alpha_enable_ff   <= tgtp_pkg::ALPHA_ENABLE_RESET;
         line_stride_ff    <= tgtp_pkg::LINE_STRIDE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            tgtp_pkg::CSR_FRAME_WIDTH: begin
               frame_width_ff <= csr_write_data[tgtp_pkg::FRAME_W-1:0];
            end
            tgtp_pkg::CSR_FRAME_HEIGHT: begin
               frame_height_ff <= csr_write_data[tgtp_pkg::FRAME_W-1:0];
            end
            tgtp_pkg::CSR_TILE_COLUMNS: begin
               tile_columns_ff <= csr_write_data[tgtp_pkg::TILE_W-1:0];
            end
            tgtp_pkg::CSR_TILE_ROWS: begin
               tile_rows_ff <= csr_write_data[tgtp_pkg::TILE_W-1:0];
            end
            tgtp_pkg::CSR_WIDE_FORMAT: begin
               wide_format_ff <= csr_write_data[0];
            end
            tgtp_pkg::CSR_CHANNEL_SHIFTS: begin
               channel_shifts_ff <= csr_write_data[tgtp_pkg::SHIFTS_W-1:0];
            end
            tgtp_pkg::CSR_ALPHA_ENABLE: begin
               alpha_enable_ff <= csr_write_data[0];
            end
            tgtp_pkg::CSR_LINE_STRIDE: begin
               line_stride_ff <= csr_write_data[tgtp_pkg::STRIDE_W-1:0];
            end
            default: begin
               line_stride_ff <= line_stride_ff;
            end
         endcase
      end
   end

   // Frame sizes above the supported maximum count as the maximum.
   always_comb begin
      width_wide   = 32'(frame_width_ff);
      height_wide  = 32'(frame_height_ff);
      col_divisor  = (width_wide > 32'(MAX_DIMENSION)) ? MAX_DIV : width_wide[DIV_W-1:0];
      row_divisor  = (height_wide > 32'(MAX_DIMENSION)) ? MAX_DIV : height_wide[DIV_W-1:0];
      width_zero   = frame_width_ff == '0;
      height_zero  = frame_height_ff == '0;
      pack_cfg.wide_format    = wide_format_ff;
      pack_cfg.channel_shifts = channel_shifts_ff;
      pack_cfg.alpha_enable   = alpha_enable_ff;
   end

   assign busy = 1'b0;

   tgtp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (start && !busy),
      .pixel_x      (req_pixel_x),
      .pixel_y      (req_pixel_y),
      .tile_columns (tile_columns_ff),
      .tile_rows    (tile_rows_ff),
      .line_stride  (line_stride_ff),
      .wide_format  (wide_format_ff),
      .valid_ff     (chain_valid[0]),
      .col_num_ff   (chain_col_num[0]),
      .row_num_ff   (chain_row_num[0]),
      .addr_ff      (chain_addr[0])
   );

   assign chain_col_rem[0]  = '0;
   assign chain_col_mod[0]  = '0;
   assign chain_row_rem[0]  = '0;
   assign chain_row_quot[0] = '0;
   assign chain_row_mod[0]  = '0;

   for (genvar i = 0; i < NUM_W; i++) begin : g_cell
      tgtp_cell #(
         .DIV_W (DIV_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .col_divisor (col_divisor),
         .row_divisor (row_divisor),
         .valid_i     (chain_valid[i]),
         .col_rem_i   (chain_col_rem[i]),
         .col_num_i   (chain_col_num[i]),
         .col_mod_i   (chain_col_mod[i]),
         .row_rem_i   (chain_row_rem[i]),
         .row_num_i   (chain_row_num[i]),
         .row_quot_i  (chain_row_quot[i]),
         .row_mod_i   (chain_row_mod[i]),
         .addr_i      (chain_addr[i]),
         .valid_ff    (chain_valid[i+1]),
         .col_rem_ff  (chain_col_rem[i+1]),
         .col_num_ff  (chain_col_num[i+1]),
         .col_mod_ff  (chain_col_mod[i+1]),
         .row_rem_ff  (chain_row_rem[i+1]),
         .row_num_ff  (chain_row_num[i+1]),
         .row_quot_ff (chain_row_quot[i+1]),
         .row_mod_ff  (chain_row_mod[i+1]),
         .addr_ff     (chain_addr[i+1])
      );
   end

   tgtp_color u_color (
      .clock                (clock),
      .reset                (reset),
      .valid_i              (chain_valid[NUM_W]),
      .col_mod_i            (chain_col_mod[NUM_W]),
      .row_mod_i            (chain_row_mod[NUM_W]),
      .row_quot_i           (chain_row_quot[NUM_W]),
      .addr_i               (chain_addr[NUM_W]),
      .tile_columns         (tile_columns_ff),
      .tile_rows            (tile_rows_ff),
      .width_zero           (width_zero),
      .height_zero          (height_zero),
      .pack_cfg             (pack_cfg),
      .rsp_valid_ff         (rsp_valid),
      .rsp_pixel_word_ff    (rsp_pixel_word),
      .rsp_byte_address_ff  (rsp_byte_address),
      .rsp_palette_index_ff (rsp_palette_index),
      .rsp_dimmed_ff        (rsp_dimmed)
   );

endmodule

[design/tgtp_checker.sv]
// Port-level checks for the tile grid test pattern core and the bind that
// attaches them. Depends on tgtp_pkg and the core's assertion macros.
`include "tile_grid_test_pattern_core_macros.svh"

module tgtp_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic [tgtp_pkg::INDEX_W-1:0]     rsp_palette_index
);

   `TGTP_ASSERT_DELAY(a_item_returns, clock, reset, start && !busy, tgtp_pkg::LATENCY, rsp_valid)
   `TGTP_ASSERT_IMPLY(a_no_invented_item, clock, reset, rsp_valid, $past(start && !busy, tgtp_pkg::LATENCY))
   `TGTP_ASSERT_IMPLY(a_index_in_palette, clock, reset, rsp_valid, rsp_palette_index < tgtp_pkg::INDEX_W'(tgtp_pkg::PALETTE_SIZE))

endmodule

bind tile_grid_test_pattern_core tgtp_checker u_tgtp_checker (.*);

[bench/tb.sv]
// Testbench for tile_grid_test_pattern_core: directed table, then random
// coordinates under random register setups, checked against a local predictor.
// Depends on tgtp_pkg and the core RTL.
module tb;

   typedef enum logic [2:0] {
      COLOR_RED     = 3'd0,
      COLOR_GREEN   = 3'd1,
      COLOR_BLUE    = 3'd2,
      COLOR_YELLOW  = 3'd3,
      COLOR_MAGENTA = 3'd4,
      COLOR_CYAN    = 3'd5,
      COLOR_WHITE   = 3'd6
   } color_code_type;

   typedef struct packed {
      logic [31:0]    word;
      logic [25:0]    addr;
      color_code_type color;
      logic           dimmed;
   } pixel_result_type;

   typedef struct packed {
      logic [11:0]      x;
      logic [11:0]      y;
      pixel_result_type result;
   } pending_pixel_type;

   typedef struct {
      bit                      is_write;
      tgtp_pkg::csr_index_type reg_index;
      int unsigned             reg_data;
      int unsigned             x;
      int unsigned             y;
      bit                      typed;
      pixel_result_type        result;
   } stim_row_type;

   localparam int unsigned DIM_LIMIT        = 4096;
   localparam int unsigned SETTLE_CYCLES    = 40;
   localparam int unsigned SETUPS_PER_PHASE = 6;
   localparam int unsigned PRINT_LIMIT      = 40;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [11:0] req_pixel_x;
   logic [11:0] req_pixel_y;
   logic        rsp_valid;
   logic [31:0] rsp_pixel_word;
   logic [25:0] rsp_byte_address;
   logic [2:0]  rsp_palette_index;
   logic        rsp_dimmed;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [19:0] csr_write_data;

   logic [12:0] frame_w      = 13'd1920;
   logic [12:0] frame_h      = 13'd1080;
   logic [7:0]  tiles_across = 8'd6;
   logic [7:0]  tiles_down   = 8'd4;
   logic        wide_pixels  = 1'b1;
   logic [19:0] lane_shifts  = 20'd407584;
   logic        alpha_on     = 1'b1;
   logic [14:0] stride_bytes = 15'd7680;

   pending_pixel_type pending_pixels [$];
   int unsigned       mismatch_count = 0;
   int unsigned       idle_pct = 27;

   stim_row_type directed_rows [$] = '{
      '{0, tgtp_pkg::CSR_FRAME_WIDTH, 0, 0, 0, 1, '{32'h000ff0ff, 26'd0, COLOR_RED, 1'b0}},
      '{0, tgtp_pkg::CSR_FRAME_WIDTH, 0, 1919, 1079, 1,
        '{32'h000000ff, 26'd8294396, COLOR_BLUE, 1'b1}},
      '{0, tgtp_pkg::CSR_FRAME_WIDTH, 0, 4095, 4095, 0, '0},
      '{0, tgtp_pkg::CSR_FRAME_WIDTH, 0, 12'haaa, 12'h555, 0, '0},
      '{1, tgtp_pkg::CSR_WIDE_FORMAT, 0, 0, 0, 0, '0},
      '{0, tgtp_pkg::CSR_FRAME_WIDTH, 0, 0, 0, 1, '{32'h0000f800, 26'd0, COLOR_RED, 1'b0}},
      '{0, tgtp_pkg::CSR_FRAME_WIDTH, 0, 1919, 1079, 1,
        '{32'h0000000f, 26'd8290558, COLOR_BLUE, 1'b1}},
      '{1, tgtp_pkg::CSR_FRAME_WIDTH, 7, 0, 0, 0, '0},
      '{1, tgtp_pkg::CSR_TILE_COLUMNS, 7, 0, 0, 0, '0},
      '{1, tgtp_pkg::CSR_FRAME_HEIGHT, 2, 0, 0, 0, '0},
      '{1, tgtp_pkg::CSR_TILE_ROWS, 2, 0, 0, 0, '0},
      '{0, tgtp_pkg::CSR_FRAME_WIDTH, 0, 0, 0, 0, '0},
      '{0, tgtp_pkg::CSR_FRAME_WIDTH, 0, 1, 0, 0, '0},
      '{0, tgtp_pkg::CSR_FRAME_WIDTH, 0, 2, 0, 0, '0},
      '{0, tgtp_pkg::CSR_FRAME_WIDTH, 0, 3, 0, 0, '0},
      '{0, tgtp_pkg::CSR_FRAME_WIDTH, 0, 4, 0, 0, '0},
      '{0, tgtp_pkg::CSR_FRAME_WIDTH, 0, 5, 0, 0, '0},
      '{0, tgtp_pkg::CSR_FRAME_WIDTH, 0, 6, 0, 0, '0},
      '{0, tgtp_pkg::CSR_FRAME_WIDTH, 0, 3, 1, 0, '0},
      '{0, tgtp_pkg::CSR_FRAME_WIDTH, 0, 6, 1, 0, '0},
      '{1, tgtp_pkg::CSR_WIDE_FORMAT, 1, 0, 0, 0, '0},
      '{1, tgtp_pkg::CSR_CHANNEL_SHIFTS, 20'hfffff, 0, 0, 0, '0},
      '{1, tgtp_pkg::CSR_ALPHA_ENABLE, 0, 0, 0, 0, '0},
      '{0, tgtp_pkg::CSR_FRAME_WIDTH, 0, 6, 0, 0, '0},
      '{0, tgtp_pkg::CSR_FRAME_WIDTH, 0, 4, 1, 0, '0},
      '{1, tgtp_pkg::CSR_CHANNEL_SHIFTS, 0, 0, 0, 0, '0},
      '{1, tgtp_pkg::CSR_ALPHA_ENABLE, 1, 0, 0, 0, '0},
      '{0, tgtp_pkg::CSR_FRAME_WIDTH, 0, 0, 0, 0, '0},
      '{1, tgtp_pkg::CSR_FRAME_WIDTH, 0, 0, 0, 0, '0},
      '{1, tgtp_pkg::CSR_FRAME_HEIGHT, 0, 0, 0, 0, '0},
      '{0, tgtp_pkg::CSR_FRAME_WIDTH, 0, 100, 200, 0, '0},
      '{1, tgtp_pkg::CSR_FRAME_WIDTH, 8191, 0, 0, 0, '0},
      '{1, tgtp_pkg::CSR_FRAME_HEIGHT, 4097, 0, 0, 0, '0},
      '{0, tgtp_pkg::CSR_FRAME_WIDTH, 0, 4095, 4095, 0, '0},
      '{0, tgtp_pkg::CSR_FRAME_WIDTH, 0, 2048, 0, 0, '0},
      '{1, tgtp_pkg::CSR_TILE_COLUMNS, 0, 0, 0, 0, '0},
      '{1, tgtp_pkg::CSR_TILE_ROWS, 0, 0, 0, 0, '0},
      '{0, tgtp_pkg::CSR_FRAME_WIDTH, 0, 7, 9, 0, '0},
      '{1, tgtp_pkg::CSR_TILE_COLUMNS, 255, 0, 0, 0, '0},
      '{1, tgtp_pkg::CSR_TILE_ROWS, 255, 0, 0, 0, '0},
      '{1, tgtp_pkg::CSR_FRAME_WIDTH, 1, 0, 0, 0, '0},
      '{1, tgtp_pkg::CSR_FRAME_HEIGHT, 1, 0, 0, 0, '0},
      '{0, tgtp_pkg::CSR_FRAME_WIDTH, 0, 4095, 4095, 0, '0},
      '{0, tgtp_pkg::CSR_FRAME_WIDTH, 0, 0, 0, 0, '0},
      '{1, tgtp_pkg::CSR_LINE_STRIDE, 15'h7fff, 0, 0, 0, '0},
      '{0, tgtp_pkg::CSR_FRAME_WIDTH, 0, 4095, 4095, 0, '0},
      '{1, tgtp_pkg::CSR_LINE_STRIDE, 0, 0, 0, 0, '0},
      '{0, tgtp_pkg::CSR_FRAME_WIDTH, 0, 4095, 4095, 0, '0}
   };

   tile_grid_test_pattern_core uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_pixel_x       (req_pixel_x),
      .req_pixel_y       (req_pixel_y),
      .rsp_valid         (rsp_valid),
      .rsp_pixel_word    (rsp_pixel_word),
      .rsp_byte_address  (rsp_byte_address),
      .rsp_palette_index (rsp_palette_index),
      .rsp_dimmed        (rsp_dimmed),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [31:0] lane(logic [7:0] value, logic [4:0] amount);
      logic [31:0] wide;
      wide = 32'(value);
      return wide << amount;
   endfunction

   function automatic pixel_result_type pattern_pixel(logic [11:0] px, logic [11:0] py);
      longint unsigned  w;
      longint unsigned  h;
      longint unsigned  col;
      longint unsigned  row;
      logic [23:0]      rgb;
      pixel_result_type res;
      w = (frame_w > DIM_LIMIT) ? DIM_LIMIT : frame_w;
      h = (frame_h > DIM_LIMIT) ? DIM_LIMIT : frame_h;
      col = (w == 0) ? 0 : (64'(px) * 64'(tiles_across)) / w;
      row = (h == 0) ? 0 : (64'(py) * 64'(tiles_down)) / h;
      res.color = color_code_type'(3'((row * 64'(tiles_across) + col) % 7));
      res.dimmed = (row >= 64'(tiles_down / 2));
      case (res.color)
         COLOR_RED:     rgb = 24'hff0000;
         COLOR_GREEN:   rgb = 24'h00ff00;
         COLOR_BLUE:    rgb = 24'h0000ff;
         COLOR_YELLOW:  rgb = 24'hffff00;
         COLOR_MAGENTA: rgb = 24'hff00ff;
         COLOR_CYAN:    rgb = 24'h00ffff;
         default:       rgb = 24'hffffff;
      endcase
      if (res.dimmed) begin
         rgb = (rgb >> 1) & 24'h7f7f7f;
      end
      if (wide_pixels) begin
         res.word = lane(rgb[23:16], lane_shifts[19:15])
                  | lane(rgb[15:8], lane_shifts[14:10])
                  | lane(rgb[7:0], lane_shifts[9:5]);
         if (alpha_on) begin
            res.word = res.word | lane(8'hff, lane_shifts[4:0]);
         end
         res.addr = 26'(64'(py) * 64'(stride_bytes) + 64'(px) * 4);
      end else begin
         res.word = {16'h0000, rgb[23:19], rgb[15:10], rgb[7:3]};
         res.addr = 26'(64'(py) * 64'(stride_bytes) + 64'(px) * 2);
      end
      return res;
   endfunction

   function automatic logic [12:0] random_size();
      case ($urandom_range(9))
         0: return 13'd0;
         1: return 13'($urandom_range(4097, 8191));
         2: return 13'd4096;
         3: return 13'd1;
         default: return 13'($urandom_range(1, 800));
      endcase
   endfunction

   function automatic logic [7:0] random_tiles();
      case ($urandom_range(9))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(1, 16));
      endcase
   endfunction

   function automatic logic [11:0] random_coord(logic [12:0] size);
      if (size == 0 || $urandom_range(9) == 0) begin
         return 12'($urandom_range(4095));
      end
      return 12'($urandom_range(((size > DIM_LIMIT) ? DIM_LIMIT : size) - 1));
   endfunction

   task automatic report(string what, logic [11:0] px, logic [11:0] py,
                         logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("ERROR %s at (%0d,%0d): got %h, expected %h", what, px, py, got, want);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_pixels.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_register(tgtp_pkg::csr_index_type idx, logic [19:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         tgtp_pkg::CSR_FRAME_WIDTH:    frame_w = data[12:0];
         tgtp_pkg::CSR_FRAME_HEIGHT:   frame_h = data[12:0];
         tgtp_pkg::CSR_TILE_COLUMNS:   tiles_across = data[7:0];
         tgtp_pkg::CSR_TILE_ROWS:      tiles_down = data[7:0];
         tgtp_pkg::CSR_WIDE_FORMAT:    wide_pixels = data[0];
         tgtp_pkg::CSR_CHANNEL_SHIFTS: lane_shifts = data;
         tgtp_pkg::CSR_ALPHA_ENABLE:   alpha_on = data[0];
         default:                      stride_bytes = data[14:0];
      endcase
      @(negedge clock);
   endtask

   task automatic send_pixel(logic [11:0] px, logic [11:0] py, bit typed,
                             pixel_result_type typed_result);
      pending_pixel_type entry;
      csr_write_enable <= 1'b0;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_pixel_x <= px;
      req_pixel_y <= py;
      do @(posedge clock); while (busy);
      entry.x = px;
      entry.y = py;
      entry.result = typed ? typed_result : pattern_pixel(px, py);
      pending_pixels.push_back(entry);
      @(negedge clock);
   endtask

   task automatic load_random_setup();
      wait_idle();
      write_register(tgtp_pkg::CSR_FRAME_WIDTH, 20'(random_size()));
      write_register(tgtp_pkg::CSR_FRAME_HEIGHT, 20'(random_size()));
      write_register(tgtp_pkg::CSR_TILE_COLUMNS, 20'(random_tiles()));
      write_register(tgtp_pkg::CSR_TILE_ROWS, 20'(random_tiles()));
      write_register(tgtp_pkg::CSR_WIDE_FORMAT, 20'($urandom_range(1)));
      if ($urandom_range(3) == 0) begin
         write_register(tgtp_pkg::CSR_CHANNEL_SHIFTS, 20'($urandom_range(20'hfffff)));
      end else begin
         write_register(tgtp_pkg::CSR_CHANNEL_SHIFTS, {5'(8 * $urandom_range(3)),
                                                       5'(8 * $urandom_range(3)),
                                                       5'(8 * $urandom_range(3)),
                                                       5'(8 * $urandom_range(3))});
      end
      write_register(tgtp_pkg::CSR_ALPHA_ENABLE, 20'($urandom_range(1)));
      if ($urandom_range(4) == 0) begin
         write_register(tgtp_pkg::CSR_LINE_STRIDE, 20'($urandom_range(15'h7fff)));
      end else begin
         write_register(tgtp_pkg::CSR_LINE_STRIDE, 20'($urandom_range(1, 16384)));
      end
   endtask

   always @(posedge clock) begin
      pending_pixel_type head;
      if (!reset && rsp_valid) begin
         if (pending_pixels.size() == 0) begin
            report("result with no item pending", 12'd0, 12'd0, rsp_pixel_word, 32'd0);
         end else begin
            head = pending_pixels.pop_front();
            if (rsp_pixel_word !== head.result.word) begin
               report("pixel_word", head.x, head.y, rsp_pixel_word, head.result.word);
            end
            if (rsp_byte_address !== head.result.addr) begin
               report("byte_address", head.x, head.y, 32'(rsp_byte_address),
                      32'(head.result.addr));
            end
            if (rsp_palette_index !== head.result.color) begin
               report("palette_index", head.x, head.y, 32'(rsp_palette_index),
                      32'(head.result.color));
            end
            if (rsp_dimmed !== head.result.dimmed) begin
               report("dimmed", head.x, head.y, 32'(rsp_dimmed), 32'(head.result.dimmed));
            end
         end
      end
   end

   initial begin
      int unsigned count;
      reset <= 1'b1;
      start <= 1'b0;
      req_pixel_x <= '0;
      req_pixel_y <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= tgtp_pkg::CSR_FRAME_WIDTH;
      csr_write_data <= '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_write) begin
            wait_idle();
            write_register(directed_rows[i].reg_index, 20'(directed_rows[i].reg_data));
         end else begin
            send_pixel(12'(directed_rows[i].x), 12'(directed_rows[i].y),
                       directed_rows[i].typed, directed_rows[i].result);
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 27 : (phase == 1) ? 46 : 0;
         for (int setup = 0; setup < SETUPS_PER_PHASE; setup++) begin
            load_random_setup();
            count = $urandom_range(20, 36);
            repeat (count) begin
               send_pixel(random_coord(frame_w), random_coord(frame_h), 1'b0, '0);
            end
         end
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+design
design/tgtp_pkg.sv
design/tgtp_front.sv
design/tgtp_cell.sv
design/tgtp_color.sv
design/tile_grid_test_pattern_core.sv
design/tgtp_checker.sv
bench/tb.sv
